// ===== sv/mbcrc_pkg.sv =====
package mbcrc_pkg;

   // CRC-16/MODBUS constants
   localparam logic [15:0] CrcInit   = 16'hFFFF;
   localparam logic [15:0] CrcPoly   = 16'hA001;
   localparam int          HeaderLen = 3;
   localparam int          PosWidth  = 9;

   // One received byte of a frame
   typedef struct packed {
      logic       frame_start;
      logic [7:0] data_byte;
   } req_item_type;

   // One frame check result
   typedef struct packed {
      logic        frame_ok;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
   } rsp_item_type;

   // Result of one processed byte, as seen by the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } frame_result_type;

   // Fold one byte into the CRC, one bit a step, LSB first
   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/mbcrc_frame_ctrl.sv =====
module mbcrc_frame_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  mbcrc_pkg::req_item_type   item,
   output mbcrc_pkg::frame_result_type result
);
   import mbcrc_pkg::*;

   logic [15:0]         crc_ff, crc_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]          count_ff, count_in;
   logic [7:0]          crc_low_ff, crc_low_in;
   logic                done_ff, done_in;

   // Walk the frame for one byte: header, payload, then the two CRC bytes
   always_comb begin
      logic [PosWidth-1:0] crc_end;
      logic [15:0]         rx_crc;
      crc_in     = crc_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      crc_low_in = crc_low_ff;
      done_in    = done_ff;
      result     = '0;
      if (item.frame_start) begin
         crc_in     = CrcInit;
         pos_in     = '0;
         count_in   = '0;
         crc_low_in = '0;
         done_in    = 1'b0;
      end
      crc_end = {1'b0, count_in} + PosWidth'(HeaderLen);
      rx_crc  = {item.data_byte, crc_low_in};
      if (!done_in) begin
         if (pos_in < PosWidth'(HeaderLen)) begin
            crc_in = crc_byte_update(crc_in, item.data_byte);
            if (pos_in == PosWidth'(HeaderLen - 1)) begin
               count_in = item.data_byte;
            end
            pos_in = pos_in + PosWidth'(1);
         end else if (pos_in < crc_end) begin
            crc_in = crc_byte_update(crc_in, item.data_byte);
            pos_in = pos_in + PosWidth'(1);
         end else if (pos_in == crc_end) begin
            crc_low_in = item.data_byte;
            pos_in     = pos_in + PosWidth'(1);
         end else begin
            result.valid             = 1'b1;
            result.item.frame_ok     = (rx_crc == crc_in);
            result.item.computed_crc = crc_in;
            result.item.received_crc = rx_crc;
            done_in                  = 1'b1;
         end
      end
   end

   // Hold frame state between bytes, advance on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CrcInit;
         pos_ff     <= '0;
         count_ff   <= '0;
         crc_low_ff <= '0;
         done_ff    <= 1'b1;
      end else if (step) begin
         crc_ff     <= crc_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         crc_low_ff <= crc_low_in;
         done_ff    <= done_in;
      end
   end

   // Position never runs past the second CRC byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> pos_ff <= ({1'b0, count_ff} + PosWidth'(HeaderLen + 1)))
      else $error("byte position beyond end of frame");

   // A result closes the frame
   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid) |=> done_ff)
      else $error("frame still open after result");

   // Outside a frame start, a result comes only on the second CRC byte
   a_result_position: assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && !item.frame_start) |->
         (pos_ff == ({1'b0, count_ff} + PosWidth'(HeaderLen + 1))))
      else $error("result at wrong byte position");

endmodule

// ===== sv/modbus_response_crc_checker_unit.sv =====
// Modbus read-response CRC checker. Feed the frame one byte per request with
// frame_start set on the address byte; byte 2 gives the payload length N. The
// block runs CRC-16/MODBUS over bytes 0 to N+2 and, on byte N+4, returns one
// result holding the computed CRC, the received CRC (low byte first) and a
// match flag. Other bytes give no result; bytes outside a frame are dropped.
// Throughput is one byte per clock while the output is not stalled: the
// byte-wide CRC update is a single combinational step between the input
// register and the frame state. A result appears on rsp_valid once its byte
// has sat in the input register and the outcome is then held in the result
// register. While a result waits at a stalled output, the byte in the input
// register is held and req_stall is raised.
// Reset is synchronous and leaves the block idle until a frame start.
module modbus_response_crc_checker_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mbcrc_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mbcrc_pkg::rsp_item_type rsp_item
);
   import mbcrc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_item_type     in_item_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_item_type     out_item_ff;
   logic             advance;
   frame_result_type result;

   // Move on unless a result is waiting at a stalled output
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? (in_valid_ff && result.valid) : out_valid_ff;

   // Capture each request into the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_item;
      end
   end

   mbcrc_frame_ctrl u_frame_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (in_valid_ff && advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && result.valid) begin
         out_item_ff <= result.item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // A processed byte that closes a frame shows up at the output next cycle
   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance && result.valid) |=> rsp_valid)
      else $error("result lost between frame logic and output");

   // A stalled request keeps its place in the input register
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff)
      else $error("input register dropped a stalled request");

endmodule
